// File: rtl/three_axis_angle_rate_estimator_assert.svh
// Assertion macros for the angle and rate estimator checker.
// Included by the checker file only; no other dependencies.
`ifndef THREE_AXIS_ANGLE_RATE_ESTIMATOR_ASSERT_SVH
`define THREE_AXIS_ANGLE_RATE_ESTIMATOR_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define TAR_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define TAR_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

// File: rtl/taare_pkg.sv
// Shared constants, types and tables for the angle and rate estimator.
// No dependencies.
package taare_pkg;
  localparam int CordicStepsDefault = 16;
  localparam int RateFracDefault = 12;
  localparam int TableLen = 24;
  localparam int AngleScale = 113;
  localparam int TiltLimit = 5832704;
  localparam int ElevLimit = 2949120;
  localparam int TwoPiQ16 = 411775;
  localparam int PiQ16 = 205887;
  localparam int HalfPiQ16 = 102944;
  localparam int CordicGainQ30 = 652032874;
  localparam int RateMax = 1048575;
  localparam int RateMin = -1048576;
  localparam int GainOne = 65536;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 17;
  localparam int InDataW = 112;
  localparam int OutDataW = 136;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TILT_GAIN  = 3'd0,
    REG_ELEV_GAIN  = 3'd1,
    REG_AZIM_GAIN  = 3'd2,
    REG_TILT_ZERO  = 3'd3,
    REG_ELEV_ZERO  = 3'd4,
    REG_AZIM_ZERO  = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_CORDIC,
    ST_MIX,
    ST_FILT,
    ST_DONE
  } state_t;

  // Shared multiply-accumulate unit control
  typedef struct packed {
    logic        start;
    logic signed [34:0] a;
    logic signed [31:0] b;
    logic signed [63:0] acc_in;
  } mac_req_t;

  function automatic logic signed [31:0] atan_q30(input logic [4:0] i);
    case (i)
      5'd0: atan_q30 = 32'sd843314856;
      5'd1: atan_q30 = 32'sd497837829;
      5'd2: atan_q30 = 32'sd263043836;
      5'd3: atan_q30 = 32'sd133525158;
      5'd4: atan_q30 = 32'sd67021686;
      5'd5: atan_q30 = 32'sd33543515;
      5'd6: atan_q30 = 32'sd16775850;
      5'd7: atan_q30 = 32'sd8388437;
      5'd8: atan_q30 = 32'sd4194282;
      5'd9: atan_q30 = 32'sd2097149;
      5'd10: atan_q30 = 32'sd1048575;
      5'd11: atan_q30 = 32'sd524287;
      5'd12: atan_q30 = 32'sd262143;
      5'd13: atan_q30 = 32'sd131071;
      5'd14: atan_q30 = 32'sd65535;
      5'd15: atan_q30 = 32'sd32767;
      5'd16: atan_q30 = 32'sd16383;
      5'd17: atan_q30 = 32'sd8191;
      5'd18: atan_q30 = 32'sd4095;
      5'd19: atan_q30 = 32'sd2047;
      5'd20: atan_q30 = 32'sd1023;
      5'd21: atan_q30 = 32'sd511;
      5'd22: atan_q30 = 32'sd255;
      5'd23: atan_q30 = 32'sd127;
      default: atan_q30 = 32'sd0;
    endcase
  endfunction
endpackage

// File: rtl/three_axis_angle_rate_estimator.sv
// Top level of the three-axis angle and rate estimator.
// Depends on taare_pkg, taare_cordic and taare_mac.
//
// A request passes through the angle fold, the CORDIC iterations and the
// single shared multiplier, used for the mix and the three filters in turn;
// the tilt angle takes one fold step for each 2*pi fold (at most 14).
// The input is not ready while a request is in work or a result waits;
// the result register holds the last result until it is taken.
module three_axis_angle_rate_estimator #(
  parameter int CORDIC_STEPS = taare_pkg::CordicStepsDefault
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tilt_raw, elevation_raw, azimuth_raw, roll_rate, pitch_rate, yaw_rate
  input  logic [taare_pkg::InDataW-1:0]     s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tilt_angle, tilt_rate, elevation_angle, elevation_rate,
  // azimuth_angle, azimuth_rate
  output logic [taare_pkg::OutDataW-1:0]    m_axis_tdata,
  input  logic                              cfg_we,
  input  logic [taare_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [taare_pkg::CfgDataW-1:0]    cfg_data
);
  import taare_pkg::*;

  state_t state, state_next;
  logic [16:0] gain_t, gain_e, gain_a;
  logic [15:0] zero_t, zero_e, zero_a;
  logic [15:0] traw, eraw, araw;
  logic signed [20:0] p, q, r;
  logic signed [23:0] tilt;
  logic signed [22:0] elev;
  logic signed [23:0] azim;
  logic signed [20:0] f_t, f_e, f_a, mixed;
  logic signed [19:0] m_red;
  logic neg;
  logic [1:0] sub;
  logic [OutDataW-1:0] out_reg;
  logic out_valid;
  logic cordic_start, cordic_done;
  logic signed [31:0] c_val, s_val;
  mac_req_t mreq;
  logic signed [63:0] macc;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_t <= 17'd32768; gain_e <= 17'd32768; gain_a <= 17'd32768;
      zero_t <= 16'd1970; zero_e <= 16'd670; zero_a <= 16'd2875;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TILT_GAIN: gain_t <= cfg_data;
        REG_ELEV_GAIN: gain_e <= cfg_data;
        REG_AZIM_GAIN: gain_a <= cfg_data;
        REG_TILT_ZERO: zero_t <= cfg_data[15:0];
        REG_ELEV_ZERO: zero_e <= cfg_data[15:0];
        REG_AZIM_ZERO: zero_a <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state == ST_IDLE) && !out_valid;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = out_reg;

  // Angle arithmetic on the captured request
  logic signed [24:0] tprod, eprod, aprod;
  logic signed [16:0] tdiff, ediff, adiff;
  always_comb begin
    tdiff = $signed({1'b0, traw}) - $signed({1'b0, zero_t});
    ediff = $signed({1'b0, zero_e}) - $signed({1'b0, eraw});
    adiff = $signed({1'b0, zero_a}) - $signed({1'b0, araw});
    tprod = 25'(tdiff) * 25'sd113;
    eprod = 25'(ediff) * 25'sd113;
    aprod = 25'(adiff) * 25'sd113;
  end

  // Range reduction: tilt is within +-89 rad, fold by 2*pi with bounded steps
  logic signed [24:0] red_cur, red_next;
  always_comb begin
    red_next = red_cur;
    if (red_cur > 25'sd205887) red_next = red_cur - 25'sd411775;
    else if (red_cur < -25'sd205887) red_next = red_cur + 25'sd411775;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (s_axis_tvalid && s_axis_tready) state_next = ST_REDUCE;
      ST_REDUCE: if (red_cur <= 25'sd205887 && red_cur >= -25'sd205887 && sub == 2'd1)
                   state_next = ST_CORDIC;
      ST_CORDIC: if (cordic_done) state_next = ST_MIX;
      ST_MIX:    if (sub == 2'd2) state_next = ST_FILT;
      ST_FILT:   if (sub == 2'd3) state_next = ST_DONE;
      ST_DONE:   state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Mix and filter operands for the shared multiplier
  logic signed [21:0] fdiff;
  logic [16:0] gsel;
  logic signed [20:0] fsel, xsel;
  always_comb begin
    unique case (sub)
      2'd0: begin fsel = f_t; xsel = q; gsel = gain_t; end
      2'd1: begin fsel = f_e; xsel = mixed; gsel = gain_e; end
      default: begin fsel = f_a; xsel = r; gsel = gain_a; end
    endcase
    if (gsel > 17'(GainOne)) gsel = 17'(GainOne);
    fdiff = 22'(xsel) - 22'(fsel);
    mreq = '0;
    if (state == ST_MIX) begin
      mreq.start = (sub != 2'd2);
      mreq.a = (sub == 2'd0) ? 35'(p) : 35'(r);
      mreq.b = (sub == 2'd0) ? (neg ? -c_val : c_val) : (neg ? -s_val : s_val);
      mreq.acc_in = (sub == 2'd0) ? 64'sd536870912 : macc;
    end else if (state == ST_FILT) begin
      mreq.start = 1'b1;
      mreq.a = 35'(fdiff);
      mreq.b = $signed({15'd0, gsel});
      mreq.acc_in = 64'sd32768;
    end
  end

  // Filter update from accumulated product
  logic signed [48:0] fsum;
  logic signed [20:0] fnew;
  logic signed [63:0] msh;
  logic [1:0] fsub;
  logic signed [20:0] fold;
  always_comb begin
    unique case (fsub)
      2'd0: fold = f_t;
      2'd1: fold = f_e;
      default: fold = f_a;
    endcase
    fsum = 49'(fold) + 49'(macc >>> 16);
    if (fsum > 49'(RateMax)) fnew = 21'(RateMax);
    else if (fsum < 49'(RateMin)) fnew = 21'(RateMin);
    else fnew = fsum[20:0];
    msh = macc >>> 30;
  end

  logic fpend;
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      f_t <= '0; f_e <= '0; f_a <= '0;
      sub <= '0;
      fpend <= 1'b0;
      fsub <= '0;
    end else begin
      state <= state_next;
      if (m_axis_tvalid && m_axis_tready) out_valid <= 1'b0;
      fpend <= (state == ST_FILT);
      fsub <= sub;
      // Drop the trailing slot of the filter pass
      if (fpend) begin
        unique case (fsub)
          2'd0: f_t <= fnew;
          2'd1: f_e <= fnew;
          2'd2: f_a <= fnew;
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE:   sub <= '0;
        ST_REDUCE: sub <= (sub == 2'd1) ? sub : sub + 2'd1;
        ST_CORDIC: sub <= '0;
        ST_MIX:    sub <= (sub == 2'd2) ? 2'd0 : sub + 2'd1;
        ST_FILT:   sub <= sub + 2'd1;
        default:   sub <= '0;
      endcase
      if (state == ST_DONE) out_valid <= 1'b1;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_axis_tvalid && s_axis_tready) begin
      traw <= s_axis_tdata[15:0];
      eraw <= s_axis_tdata[31:16];
      araw <= s_axis_tdata[47:32];
      p <= s_axis_tdata[68:48];
      q <= s_axis_tdata[89:69];
      r <= s_axis_tdata[110:90];
    end
    if (state == ST_REDUCE) begin
      if (sub == 2'd0) begin
        tilt <= (tprod > 25'sd5832704) ? 24'sd5832704 :
                (tprod < -25'sd5832704) ? -24'sd5832704 : tprod[23:0];
        elev <= (eprod > 25'sd2949120) ? 23'sd2949120 :
                (eprod < -25'sd2949120) ? -23'sd2949120 : eprod[22:0];
        azim <= aprod[23:0];
        red_cur <= (tprod > 25'sd5832704) ? 25'sd5832704 :
                   (tprod < -25'sd5832704) ? -25'sd5832704 : tprod;
      end else begin
        red_cur <= red_next;
      end
    end
    if (state == ST_REDUCE && state_next == ST_CORDIC) begin
      if (red_cur > 25'sd102944) begin
        m_red <= 20'(red_cur - 25'sd205887); neg <= 1'b1;
      end else if (red_cur < -25'sd102944) begin
        m_red <= 20'(red_cur + 25'sd205887); neg <= 1'b1;
      end else begin
        m_red <= 20'(red_cur); neg <= 1'b0;
      end
    end
    if (state == ST_MIX && sub == 2'd2) begin
      mixed <= (msh > 64'(RateMax)) ? 21'(RateMax) :
               (msh < 64'(RateMin)) ? 21'(RateMin) : msh[20:0];
    end
    if (state == ST_DONE) begin
      out_reg <= {2'b0, 21'(f_a), 24'(azim), 21'(f_e), 23'(elev), 21'(f_t), 24'(tilt)};
    end
  end

  assign cordic_start = (state == ST_REDUCE) && (state_next == ST_CORDIC);

  logic signed [31:0] cordic_angle;
  assign cordic_angle = 32'(m_red) <<< 14;

  logic cstart_d;
  always_ff @(posedge clk) begin
    if (rst) cstart_d <= 1'b0;
    else cstart_d <= cordic_start;
  end

  taare_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .start(cstart_d), .angle(cordic_angle),
    .done(cordic_done), .cos_out(c_val), .sin_out(s_val)
  );

  taare_mac u_mac (.clk(clk), .req(mreq), .acc(macc));

  logic unused_w;
  assign unused_w = s_axis_tdata[111];
endmodule

// File: rtl/taare_cordic.sv
// One-step-per-cycle CORDIC rotation unit, Q.30, shared shifter and adders.
// Depends on taare_pkg.
module taare_cordic #(
  parameter int CORDIC_STEPS = taare_pkg::CordicStepsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] angle,
  output logic               done,
  output logic signed [31:0] cos_out,
  output logic signed [31:0] sin_out
);
  import taare_pkg::*;

  localparam int Steps = (CORDIC_STEPS > TableLen) ? TableLen : CORDIC_STEPS;

  logic signed [33:0] x, y, z;
  logic [4:0] step;
  logic busy;

  // Run one micro-rotation per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == 5'(Steps - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= 34'(CordicGainQ30);
      y <= '0;
      z <= 34'(angle);
    end else if (busy) begin
      if (!z[33]) begin
        x <= x - (y >>> step);
        y <= y + (x >>> step);
        z <= z - 34'(atan_q30(step));
      end else begin
        x <= x + (y >>> step);
        y <= y - (x >>> step);
        z <= z + 34'(atan_q30(step));
      end
    end
  end

  assign cos_out = x[31:0];
  assign sin_out = y[31:0];
endmodule

// File: rtl/taare_mac.sv
// Shared signed multiply-accumulate unit, registered result.
// Depends on taare_pkg.
module taare_mac (
  input  logic                   clk,
  input  taare_pkg::mac_req_t    req,
  output logic signed [63:0]     acc
);
  import taare_pkg::*;

  logic signed [66:0] prod;

  // One registered multiply and add per request
  assign prod = 67'(req.a) * 67'(req.b) + 67'(req.acc_in);

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc <= prod[63:0];
    end
  end
endmodule

// File: rtl/taare_checker.sv
// Port-level checker for the angle and rate estimator, with its bind.
// Depends on taare_pkg and three_axis_angle_rate_estimator_assert.svh.
`include "three_axis_angle_rate_estimator_assert.svh"
module taare_checker (
  input logic clk,
  input logic rst,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [taare_pkg::OutDataW-1:0] m_axis_tdata
);
  import taare_pkg::*;

  // No new request while a result waits
  `TAR_ASSERT_IMP(a_no_accept_pending, m_axis_tvalid, !s_axis_tready)
  // Accepted request blocks the input next cycle
  `TAR_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // A result is never shown in the cycle after a request
  `TAR_ASSERT_NEXT(a_no_instant_result, s_axis_tvalid && s_axis_tready, !m_axis_tvalid)
  // Pad bit stays clear
  `TAR_ASSERT_IMP(a_pad_zero, m_axis_tvalid, m_axis_tdata[OutDataW-1] == 1'b0)
endmodule

bind three_axis_angle_rate_estimator taare_checker u_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
